// ----- hdl/lskhc_pkg.sv -----
// Shared types and constants of the size-keyed handle cache.
`default_nettype none
package lskhc_pkg;

    localparam int unsigned KEY_W   = 13;
    localparam int unsigned STAMP_W = 64;
    // Covers the largest supported slot count of 256.
    localparam int unsigned IDX_W   = 8;

    // Operation codes carried in the input tuser.
    localparam logic       OP_REQ     = 1'b0;
    localparam logic       OP_CLR     = 1'b1;

    // Status codes carried in the output tuser.
    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_LOADED  = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    // Search token that travels down the row of slot cells.
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic               free;
        logic [IDX_W-1:0]   free_idx;
        logic               have_min;
        logic [IDX_W-1:0]   min_idx;
        logic [STAMP_W-1:0] min_stamp;
        logic [KEY_W-1:0]   min_key;
    } t_scan;

    // Update broadcast from the controller to every cell.
    typedef struct packed {
        logic               clr;
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_wr;

endpackage
`default_nettype wire

// ----- hdl/lskhc_cell.sv -----
// One slot cell: holds a slot's valid bit, key and stamp and folds them into the search token.
`default_nettype none
module lskhc_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lskhc_pkg::t_scan             i_tok,
    input  wire logic [lskhc_pkg::KEY_W-1:0]  i_key,
    input  wire lskhc_pkg::t_wr               i_wr,
    output lskhc_pkg::t_scan                  o_tok
);
    import lskhc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [STAMP_W-1:0] r_stamp;
    t_scan              r_tok;
    t_scan              n_tok;

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && r_valid && (r_key == i_key)) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = MY_IDX;
        end
        if (!i_tok.free && !r_valid) begin
            n_tok.free     = 1'b1;
            n_tok.free_idx = MY_IDX;
        end
        // Strict compare keeps the lowest index on equal stamps.
        if (!i_tok.have_min || (r_stamp < i_tok.min_stamp)) begin
            n_tok.have_min  = 1'b1;
            n_tok.min_idx   = MY_IDX;
            n_tok.min_stamp = r_stamp;
            n_tok.min_key   = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.clr) begin
                r_valid <= 1'b0;
            end else if (i_wr.en && (i_wr.idx == MY_IDX)) begin
                r_valid <= i_wr.valid;
                if (i_wr.valid) begin
                    r_key   <= i_wr.key;
                    r_stamp <= i_wr.stamp;
                end
            end
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

// ----- hdl/lru_size_keyed_handle_cache_unit.sv -----
// Top level of the size-keyed LRU handle cache: controller, use counter and the row of cells.
//
// Input stream (s_axis): tuser is the opcode (0 request, 1 clear); tdata carries the
// requested size in unsigned 12.4 fixed point and the external load outcome for a miss.
// Output stream (m_axis): tuser is the status (hit, loaded, load failed, cleared); tdata
// carries the slot handle, the quantized key and the eviction report.
// A request sends a search token down the row of SLOTS cells, one cell per cycle, which
// collects the hit, the first free slot and the least recently used slot. A clear skips
// the scan. One item is handled at a time: a new item is taken only in the idle state.
// The result sits in an output register; the next item is taken while it waits, but the
// table update and the next result wait until the receiver has taken the previous result.
// Reset empties every slot and zeroes the use counter at once; no clearing pass is needed.
// slot_index carries the low six bits of the slot number.
`default_nettype none
module lru_size_keyed_handle_cache_unit #(
    parameter int unsigned SLOTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [15:0] request_size, [16] load_ok, rest zero
    input  wire logic        s_axis_tuser,  // [0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [5:0] slot_index, [18:6] quantized_size,
                                            // [19] evicted, [32:20] evicted_size, rest zero
    output logic [1:0]       m_axis_tuser   // [1:0] status
);
    import lskhc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state             r_state;
    logic               r_start;
    logic               r_op;
    logic               r_load_ok;
    logic [KEY_W-1:0]   r_key;
    logic [STAMP_W-1:0] r_ctr;
    t_scan              r_fin;
    logic               r_out_vld;
    logic [1:0]         r_out_status;
    logic [39:0]        r_out_data;

    t_scan              w_tok [SLOTS+1];
    t_wr                w_wr;
    logic               w_in_fire;
    logic               w_done;
    logic [KEY_W-1:0]   w_qkey;
    logic [16:0]        w_round;
    logic [STAMP_W-1:0] w_ctr_inc;
    logic [1:0]         d_status;
    logic [IDX_W-1:0]   d_idx;
    logic               d_ev;
    logic [KEY_W-1:0]   d_evsz;
    logic               d_bump;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_done        = (r_state == S_DONE) && (!r_out_vld || m_axis_tready);
    assign w_ctr_inc     = r_ctr + STAMP_W'(1);

    // Sizes at or below 1.0 map to 1; others round half up to an integer.
    assign w_round = {1'b0, s_axis_tdata[15:0]} + 17'd8;
    assign w_qkey  = (s_axis_tdata[15:0] <= 16'd16) ? KEY_W'(1) : w_round[16:4];

    always_comb begin
        w_tok[0]     = '0;
        w_tok[0].vld = r_start;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lskhc_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[g]),
            .i_key  (r_key),
            .i_wr   (w_wr),
            .o_tok  (w_tok[g+1])
        );
    end

    always_comb begin
        d_status = ST_CLEARED;
        d_idx    = '0;
        d_ev     = 1'b0;
        d_evsz   = '0;
        d_bump   = 1'b0;
        w_wr     = '0;
        if (r_op == OP_CLR) begin
            w_wr.clr = w_done;
        end else begin
            if (r_fin.hit) begin
                d_status = ST_HIT;
                d_idx    = r_fin.hit_idx;
                d_bump   = 1'b1;
            end else begin
                if (r_fin.free) begin
                    d_idx = r_fin.free_idx;
                end else begin
                    d_idx  = r_fin.min_idx;
                    d_ev   = 1'b1;
                    d_evsz = r_fin.min_key;
                end
                d_status = r_load_ok ? ST_LOADED : ST_FAILED;
                d_bump   = r_load_ok;
            end
            w_wr.en    = w_done;
            w_wr.idx   = d_idx;
            w_wr.valid = d_bump;
            w_wr.key   = r_key;
            w_wr.stamp = w_ctr_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_ctr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_vld && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_op      <= s_axis_tuser;
                        r_key     <= w_qkey;
                        r_load_ok <= s_axis_tdata[16];
                        if (s_axis_tuser == OP_REQ) begin
                            r_start <= 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_tok[SLOTS].vld) begin
                        r_fin   <= w_tok[SLOTS];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_done) begin
                        if (r_op == OP_CLR) begin
                            r_ctr <= '0;
                        end else if (d_bump) begin
                            r_ctr <= w_ctr_inc;
                        end
                        r_out_vld    <= 1'b1;
                        r_out_status <= d_status;
                        r_out_data   <= {7'd0, d_evsz, d_ev, (r_op == OP_CLR) ? 13'd0 : r_key,
                                         d_idx[5:0]};
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[19]) |->
        (m_axis_tuser == ST_LOADED || m_axis_tuser == ST_FAILED))
        else $error("eviction reported on a hit or clear");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_CLEARED) |-> (m_axis_tdata == 40'd0))
        else $error("clear result carries nonzero fields");

    a_key_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_CLEARED) |-> (m_axis_tdata[18:6] != 13'd0))
        else $error("request result with zero key");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[SLOTS].vld |-> (r_state == S_SCAN))
        else $error("search token left the row outside a scan");

endmodule
`default_nettype wire

// ----- tb/lru_size_keyed_handle_cache_unit_test.sv -----
// Self-checking testbench of the size-keyed LRU handle cache with a stream driver and monitor.
`default_nettype none
module lru_size_keyed_handle_cache_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lskhc_pkg::*;

    localparam int unsigned SLOTS       = 64;
    localparam int unsigned CLK_PERIOD  = 8;
    localparam int unsigned PHASE_ITEMS = 660;
    localparam int unsigned HOLD_CYCLES = 500;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PRINT_LIMIT = 50;

    typedef struct packed {
        logic        opcode;
        logic [15:0] size;
        logic        load_ok;
    } t_handle_request;

    typedef struct packed {
        logic [1:0]       status;
        logic [5:0]       slot;
        logic [KEY_W-1:0] qsize;
        logic             evicted;
        logic [KEY_W-1:0] ev_size;
    } t_handle_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [15:0] request_size, [16] load_ok, rest zero
    logic        s_axis_tuser = 1'b0; // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [5:0] slot_index, [18:6] quantized_size,
                                      // [19] evicted, [32:20] evicted_size, rest zero
    logic [1:0]  m_axis_tuser;        // [1:0] status

    lru_size_keyed_handle_cache_unit #(
        .SLOTS(SLOTS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the cache table.
    bit               slot_live  [SLOTS];
    bit [KEY_W-1:0]   slot_key   [SLOTS];
    bit [STAMP_W-1:0] slot_stamp [SLOTS];
    bit [STAMP_W-1:0] use_count;

    t_handle_request pending_requests [$];
    t_handle_result  expected_results [$];
    t_handle_request on_bus;
    t_handle_result  want;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit          hold_armed = 1'b0;
    bit          hold_used = 1'b0;

    function automatic t_handle_result cache_access(t_handle_request r);
        t_handle_result   res;
        logic [KEY_W-1:0] key;
        int               pick;
        int               i;
        res = '0;
        if (r.opcode == OP_CLR) begin
            for (i = 0; i < SLOTS; i++) begin
                slot_live[i]  = 1'b0;
                slot_key[i]   = '0;
                slot_stamp[i] = '0;
            end
            use_count  = '0;
            res.status = ST_CLEARED;
            return res;
        end
        // Sizes up to 1.0 map to 1; the rest round half up.
        if (r.size <= 16'd16) key = KEY_W'(1);
        else key = KEY_W'((32'(r.size) + 32'd8) >> 4);
        res.qsize = key;
        pick = -1;
        for (i = 0; i < SLOTS; i++) begin
            if (pick < 0 && slot_live[i] && slot_key[i] == key) pick = i;
        end
        if (pick >= 0) begin
            use_count        = use_count + 1;
            slot_stamp[pick] = use_count;
            res.status       = ST_HIT;
            res.slot         = 6'(pick);
            return res;
        end
        for (i = 0; i < SLOTS; i++) begin
            if (pick < 0 && !slot_live[i]) pick = i;
        end
        if (pick < 0) begin
            // Table full: the oldest stamp goes, lowest index on a tie.
            pick = 0;
            for (i = 1; i < SLOTS; i++) begin
                if (slot_stamp[i] < slot_stamp[pick]) pick = i;
            end
            res.evicted     = 1'b1;
            res.ev_size     = slot_key[pick];
            slot_live[pick] = 1'b0;
        end
        if (r.load_ok) begin
            use_count        = use_count + 1;
            slot_key[pick]   = key;
            slot_live[pick]  = 1'b1;
            slot_stamp[pick] = use_count;
            res.status       = ST_LOADED;
        end else begin
            res.status = ST_FAILED;
        end
        res.slot = 6'(pick);
        return res;
    endfunction

    function automatic t_handle_request random_request();
        t_handle_request r;
        int unsigned     roll;
        int unsigned     key;
        int unsigned     raw;
        roll      = $urandom_range(0, 99);
        r.opcode  = (roll < 2) ? OP_CLR : OP_REQ;
        r.load_ok = ($urandom_range(0, 99) < 85);
        if (roll < 30) begin
            r.size = 16'($urandom);
        end else begin
            // A small pool of keys at each end of the range keeps hits and evictions frequent.
            key = $urandom_range(1, 90);
            if (roll >= 80) key = 4097 - key;
            if (key == 1) begin
                raw = $urandom_range(0, 23);
            end else begin
                raw = key * 16 - 8 + $urandom_range(0, 15);
            end
            if (raw > 65535) raw = 65535;
            r.size = 16'(raw);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_val);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("mismatch in %s: got %0d, expected %0d, cycle %0d",
                     what, got, exp_val, cycle_count);
        end
    endtask

    task automatic push_request(logic op, logic [15:0] size, logic ok);
        t_handle_request r;
        r.opcode  = op;
        r.size    = size;
        r.load_ok = ok;
        pending_requests.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Driver: predicts each accepted transfer, then offers the next pending request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(cache_access(on_bus));
                accepted_count <= accepted_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    on_bus = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, on_bus.load_ok, on_bus.size};
                    s_axis_tuser  <= on_bus.opcode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, armed once from the stimulus sequence.
    always @(posedge i_clk) begin
        if (hold_armed && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", m_axis_tuser, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser != want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tdata[5:0] != want.slot)
                        report_mismatch("slot_index", m_axis_tdata[5:0], want.slot);
                    if (m_axis_tdata[18:6] != want.qsize)
                        report_mismatch("quantized_size", m_axis_tdata[18:6], want.qsize);
                    if (m_axis_tdata[19] != want.evicted)
                        report_mismatch("evicted", m_axis_tdata[19], want.evicted);
                    if (m_axis_tdata[32:20] != want.ev_size)
                        report_mismatch("evicted_size", m_axis_tdata[32:20], want.ev_size);
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int unsigned n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: rounding edges, both load outcomes, hits and clears.
        push_request(OP_REQ, 16'd0, 1'b1);
        push_request(OP_REQ, 16'd16, 1'b1);
        push_request(OP_REQ, 16'd17, 1'b0);
        push_request(OP_REQ, 16'd23, 1'b1);
        push_request(OP_REQ, 16'd24, 1'b0);
        push_request(OP_REQ, 16'd24, 1'b1);
        push_request(OP_REQ, 16'd39, 1'b1);
        push_request(OP_REQ, 16'hFFFF, 1'b1);
        push_request(OP_REQ, 16'd65527, 1'b1);
        push_request(OP_REQ, 16'd65528, 1'b0);
        push_request(OP_REQ, 16'hAAAA, 1'b0);
        push_request(OP_REQ, 16'h5555, 1'b1);
        push_request(OP_REQ, 16'hAAAA, 1'b1);
        push_request(OP_CLR, 16'hFFFF, 1'b1);
        push_request(OP_CLR, 16'h0000, 1'b0);
        push_request(OP_REQ, 16'hFFFF, 1'b0);
        push_request(OP_REQ, 16'h5555, 1'b1);
        push_request(OP_REQ, 16'd0, 1'b1);
        push_request(OP_REQ, 16'd40, 1'b1);
        push_request(OP_CLR, 16'h1234, 1'b0);
        push_request(OP_REQ, 16'd40, 1'b1);
        wait_idle();

        tx_idle_pct = 20;
        rx_idle_pct = 68;
        for (n = 0; n < PHASE_ITEMS; n++) pending_requests.push_back(random_request());
        wait_idle();

        tx_idle_pct = 68;
        rx_idle_pct = 20;
        for (n = 0; n < PHASE_ITEMS; n++) pending_requests.push_back(random_request());
        wait_idle();

        // No idling; the receiver stops for a long stretch so the input side backs up.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        n = accepted_count;
        for (int k = 0; k < PHASE_ITEMS; k++) pending_requests.push_back(random_request());
        while (accepted_count < n + 40) @(negedge i_clk);
        hold_armed = 1'b1;
        wait_idle();

        repeat (SLOTS + 10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
